// ----- hdl/multilevel_ready_queue_unit_macros.svh -----
// Assertion macros for the multilevel ready queue unit
`ifndef MULTILEVEL_READY_QUEUE_UNIT_MACROS_SVH
`define MULTILEVEL_READY_QUEUE_UNIT_MACROS_SVH
// implication checked every clock, disabled in reset
`define MRQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MRQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hdl/mrq_pkg.sv -----
// Package for the multilevel ready queue: widths, codes, packing
`default_nettype none
package mrq_pkg;
  localparam int TidW = 6;
  localparam int LvlW = 6;
  localparam int NumThreads = 64;
  localparam int NumLevels = 64;
  localparam int CntW = 7;
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_POP = 3'd1;
  localparam logic [2:0] OP_PEEK = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_MOVE = 3'd4;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_QUEUED = 2'd2;
  localparam logic [1:0] ST_NOTQ = 2'd3;
  typedef logic [15:0] in_word_t;
  typedef logic [23:0] out_word_t;
endpackage
`default_nettype wire

// ----- hdl/multilevel_ready_queue_unit.sv -----
// Multilevel ready queue unit: 64 per-level FIFOs of thread ids in link memories
// Each command passes through accept, a read of the thread's level and of the
// head of the top level, a read of the links and of the head/tail entries that
// those select, then write-back with the result loaded into the output register.
// The next command is accepted in the cycle after write-back. The command word is
// taken while the previous result waits at the output; write-back stalls while
// the output register still holds an unaccepted result. The rate is set by the
// two dependent memory reads that each command needs before it can update them.
// A level bitmap with a priority encoder picks the highest non-empty level.
`default_nettype none
module multilevel_ready_queue_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire mrq_pkg::in_word_t s_tdata, // operation, thread_id, priority_req, pad
  output logic m_tvalid,
  input  wire logic m_tready,
  output mrq_pkg::out_word_t m_tdata // status, out_thread, out_priority, ready_count, pad
);
  import mrq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state;
  logic [2:0] op;
  logic [TidW-1:0] tid;
  logic [LvlW-1:0] preq;
  logic [NumLevels-1:0] nonempty;
  logic [NumThreads-1:0] queued;
  logic [CntW-1:0] total;
  logic commit;

  logic [TidW-1:0] head_mem [NumLevels];
  logic [TidW-1:0] tail_mem [NumLevels];
  logic [TidW-1:0] next_mem [NumThreads];
  logic [TidW-1:0] prev_mem [NumThreads];
  logic [LvlW-1:0] lvl_mem [NumThreads];

  // read stage registers
  logic [TidW-1:0] r_head, r_tail, r_next, r_prev, r_ptail;
  logic [LvlW-1:0] r_lvl;
  logic [LvlW-1:0] top;
  logic top_ok;
  logic [TidW-1:0] tgt;

  // highest non-empty level
  always_comb begin
    top = '0;
    top_ok = 1'b0;
    for (int i = 0; i < NumLevels; i++) begin
      if (nonempty[i]) begin
        top = LvlW'(i);
        top_ok = 1'b1;
      end
    end
  end

  logic [LvlW-1:0] lvl_rd;
  logic [TidW-1:0] tgt_rd;
  always_comb begin
    tgt_rd = ((op == OP_POP) || (op == OP_PEEK)) ? '0 : tid;
    lvl_rd = top;
  end

  // phase 0: read thread's level and top-level head; phase 1: read links of the
  // target thread, head/tail of its level and tail of push level
  logic [1:0] phase;
  logic [TidW-1:0] pop_tid;
  logic [LvlW-1:0] lv;
  always_ff @(posedge clk) begin
    if (state == S_READ && phase == 2'd0) begin
      r_lvl <= lvl_mem[tid];
      pop_tid <= head_mem[lvl_rd];
    end
    if (state == S_READ && phase == 2'd1) begin
      r_next <= next_mem[tgt];
      r_prev <= prev_mem[tgt];
      r_head <= head_mem[lv];
      r_tail <= tail_mem[lv];
      r_ptail <= tail_mem[preq];
    end
  end
  always_comb begin
    tgt = ((op == OP_POP) || (op == OP_PEEK)) ? pop_tid : tgt_rd;
    lv = (op == OP_POP) ? top : r_lvl;
  end

  // exec decisions
  logic do_unlink, do_append;
  logic [1:0] st;
  logic [TidW-1:0] othr;
  logic [LvlW-1:0] oprio;
  logic is_head, is_tail;
  logic [NumLevels-1:0] ne_mid;
  logic app_nonempty;
  always_comb begin
    do_unlink = 1'b0;
    do_append = 1'b0;
    st = ST_OK;
    othr = tid;
    oprio = '0;
    case (op)
      OP_PUSH: begin
        if (queued[tid]) begin
          st = ST_QUEUED;
          oprio = r_lvl;
        end else begin
          do_append = 1'b1;
          oprio = preq;
        end
      end
      OP_POP, OP_PEEK: begin
        if (!top_ok) begin
          st = ST_EMPTY;
          othr = '0;
        end else begin
          othr = pop_tid;
          oprio = top;
          do_unlink = (op == OP_POP);
        end
      end
      OP_REMOVE: begin
        if (!queued[tid]) st = ST_NOTQ;
        else begin
          oprio = r_lvl;
          do_unlink = 1'b1;
        end
      end
      OP_MOVE: begin
        if (!queued[tid]) st = ST_NOTQ;
        else begin
          do_unlink = 1'b1;
          do_append = 1'b1;
          oprio = preq;
        end
      end
      default: ;
    endcase
    is_head = (r_head == tgt);
    is_tail = (r_tail == tgt);
    ne_mid = nonempty;
    if (do_unlink && is_head && is_tail) ne_mid[lv] = 1'b0;
    app_nonempty = ne_mid[preq];
  end

  // tail of push level after the unlink (move within same level)
  logic [TidW-1:0] ptail;
  always_comb begin
    ptail = r_ptail;
    if (do_unlink && (lv == preq) && is_tail && !is_head) ptail = r_prev;
  end

  logic [CntW-1:0] total_next;
  always_comb begin
    total_next = total;
    if (do_unlink && total != '0) total_next = total_next - 1'b1;
    if (do_append) total_next = total_next + 1'b1;
  end

  logic [NumLevels-1:0] nonempty_next;
  logic [NumThreads-1:0] queued_next;
  always_comb begin
    nonempty_next = ne_mid;
    queued_next = queued;
    if (do_unlink) queued_next[tgt] = 1'b0;
    if (do_append) begin
      nonempty_next[preq] = 1'b1;
      queued_next[tid] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (do_unlink) begin
        if (is_head && !is_tail) begin
          head_mem[lv] <= r_next;
          prev_mem[r_next] <= r_next;
        end else if (is_tail && !is_head) begin
          if (!(do_append && (lv == preq))) tail_mem[lv] <= r_prev;
          if (!(do_append && app_nonempty && (ptail == r_prev))) next_mem[r_prev] <= r_prev;
        end else if (!is_head && !is_tail) begin
          next_mem[r_prev] <= r_next;
          prev_mem[r_next] <= r_prev;
        end
      end
      if (do_append) begin
        if (app_nonempty) begin
          next_mem[ptail] <= tid;
          prev_mem[tid] <= ptail;
        end else begin
          head_mem[preq] <= tid;
          prev_mem[tid] <= tid;
        end
        next_mem[tid] <= tid;
        tail_mem[preq] <= tid;
        lvl_mem[tid] <= preq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 2'd0;
      m_tvalid <= 1'b0;
      nonempty <= '0;
      queued <= '0;
      total <= '0;
    end else begin
      if (commit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            op <= s_tdata[2:0];
            tid <= s_tdata[8:3];
            preq <= s_tdata[14:9];
            phase <= 2'd0;
            state <= S_READ;
          end
        end
        S_READ: begin
          phase <= phase + 2'd1;
          if (phase == 2'd1) state <= S_EXEC;
        end
        S_EXEC: begin
          if (commit) begin
            nonempty <= nonempty_next;
            queued <= queued_next;
            total <= total_next;
            m_tdata <= {3'b0, total_next, oprio, othr, st};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign commit = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign s_tready = (state == S_IDLE);

  `include "multilevel_ready_queue_unit_macros.svh"
  `MRQ_ASSERT_IMP(a_cnt, 1'b1, total == CntW'($countones(queued)), "count mismatch")
  `MRQ_ASSERT_NXT(a_busy, state != S_IDLE, !s_tready || state == S_IDLE, "ready while busy")
  `MRQ_ASSERT_IMP(a_empty, total == '0, nonempty == '0, "level bit without thread")
  `MRQ_ASSERT_NXT(a_res, state == S_EXEC && (!m_tvalid || m_tready), m_tvalid, "result lost")
endmodule
`default_nettype wire
